// ----- rtl/swrp_pkg.sv -----
// Shared types, codes and the checksum function of the stop-and-wait receiver.
`timescale 1ns / 1ps
package swrp_pkg;

    localparam int unsigned MAX_PAYLOAD = 1024;
    localparam logic [15:0] MAX_LEN     = 16'(MAX_PAYLOAD);

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [3:0]  FILES_RESET   = 4'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FILES   = 1'b1;

    // Input commands.
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Header tags.
    localparam logic [7:0] TAG_SYN    = 8'h01;
    localparam logic [7:0] TAG_ACK    = 8'h02;
    localparam logic [7:0] TAG_SYNACK = 8'h03;
    localparam logic [7:0] TAG_FIN    = 8'h04;
    localparam logic [7:0] TAG_FINACK = 8'h06;
    localparam logic [7:0] TAG_OVER   = 8'h07;

    // Result status codes.
    localparam logic [2:0] ST_NONE       = 3'd0;
    localparam logic [2:0] ST_CONNECTED  = 3'd1;
    localparam logic [2:0] ST_CONN_FAIL  = 3'd2;
    localparam logic [2:0] ST_DUPLICATE  = 3'd3;
    localparam logic [2:0] ST_FILE_DONE  = 3'd4;
    localparam logic [2:0] ST_CLOSED     = 3'd5;
    localparam logic [2:0] ST_CLOSE_FAIL = 3'd6;

    // Depth of the queue between the front and the back.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        command;
        logic [7:0]  pkt_tag;
        logic [7:0]  pkt_seq;
        logic [15:0] pkt_datasize;
        logic [15:0] pkt_checksum;
    } t_in_item;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_tag;
        logic [7:0]  send_seq;
        logic [15:0] send_datasize;
        logic [15:0] send_checksum;
        logic        last;
        logic        deliver;
        logic [15:0] deliver_len;
        logic [3:0]  file_index;
        logic [31:0] byte_count;
        logic [2:0]  status;
    } t_out_item;

    // Result without its checksum, as decided by the front.
    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_tag;
        logic [7:0]  send_seq;
        logic [15:0] send_datasize;
        logic        last;
        logic        deliver;
        logic [15:0] deliver_len;
        logic [3:0]  file_index;
        logic [31:0] byte_count;
        logic [2:0]  status;
    } t_action;

    // Write side of the action queue: up to two actions per request.
    typedef struct packed {
        logic [1:0] count;
        t_action    act0;
        t_action    act1;
    } t_qwrite;

    // Ones-complement sum of three words with end-around carry, complemented.
    function automatic logic [15:0] ones_sum(input logic [15:0] w0,
                                             input logic [15:0] w1,
                                             input logic [15:0] w2);
        logic [16:0] s;
        begin
            s = {1'b0, w0} + {1'b0, w1};
            if (s[16]) begin
                s = {1'b0, s[15:0]} + 17'd1;
            end
            s = {1'b0, s[15:0]} + {1'b0, w2};
            if (s[16]) begin
                s = {1'b0, s[15:0]} + 17'd1;
            end
            return ~s[15:0];
        end
    endfunction

endpackage

// ----- rtl/swrp_front.sv -----
// Front part: protocol state machine that accepts requests and decides the results.
`timescale 1ns / 1ps
module swrp_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [swrp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [15:0]                      i_cfg_wdata,
    input  logic                             i_accept,
    input  swrp_pkg::t_in_item               i_item,
    output swrp_pkg::t_qwrite                o_qwr
);

    typedef enum logic [2:0] {
        PH_WAIT_SYN,
        PH_WAIT_ACK,
        PH_DATA,
        PH_WAIT_FIN,
        PH_WAIT_LAST,
        PH_CLOSED
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic [7:0]  r_exp_seq,    n_exp_seq;
    logic [15:0] r_timer,      n_timer;
    logic [7:0]  r_rs_tag,     n_rs_tag;
    logic [7:0]  r_rs_seq,     n_rs_seq;
    logic [15:0] r_rs_ds,      n_rs_ds;
    logic [3:0]  r_files_done, n_files_done;
    logic [31:0] r_file_bytes, n_file_bytes;
    logic [7:0]  r_last_ack,   n_last_ack;
    logic [15:0] r_timeout;
    logic [3:0]  r_files_cfg;

    logic                hdr_ok;
    logic [15:0]         timer_inc;
    logic [15:0]         len;
    logic [32:0]         byte_sum;
    logic [3:0]          files_inc;
    swrp_pkg::t_action   base;
    swrp_pkg::t_qwrite   qwr;

    assign hdr_ok    = (swrp_pkg::ones_sum(i_item.pkt_datasize, i_item.pkt_checksum,
                                           {i_item.pkt_seq, i_item.pkt_tag}) == 16'd0);
    assign timer_inc = (r_timer < 16'hffff) ? (r_timer + 16'd1) : r_timer;
    assign len       = (i_item.pkt_datasize > swrp_pkg::MAX_LEN) ? swrp_pkg::MAX_LEN
                                                                 : i_item.pkt_datasize;
    assign byte_sum  = {1'b0, r_file_bytes} + {17'd0, len};
    assign files_inc = r_files_done + 4'd1;

    always_comb begin
        base             = '0;
        base.last        = 1'b1;
        base.file_index  = r_files_done;
        base.byte_count  = r_file_bytes;
        base.status      = swrp_pkg::ST_NONE;

        qwr          = '0;
        qwr.act0     = base;
        qwr.act1     = base;
        n_phase      = r_phase;
        n_exp_seq    = r_exp_seq;
        n_timer      = r_timer;
        n_rs_tag     = r_rs_tag;
        n_rs_seq     = r_rs_seq;
        n_rs_ds      = r_rs_ds;
        n_files_done = r_files_done;
        n_file_bytes = r_file_bytes;
        n_last_ack   = r_last_ack;

        if (i_accept) begin
            if (i_item.command == swrp_pkg::CMD_TICK) begin
                if ((r_phase == PH_WAIT_ACK) || (r_phase == PH_WAIT_LAST)) begin
                    if (timer_inc < r_timeout) begin
                        n_timer = timer_inc;
                    end else begin
                        n_timer                 = '0;
                        qwr.count               = 2'd1;
                        qwr.act0.send_valid     = 1'b1;
                        qwr.act0.send_tag       = r_rs_tag;
                        qwr.act0.send_seq       = r_rs_seq;
                        qwr.act0.send_datasize  = r_rs_ds;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_WAIT_SYN: begin
                        if ((i_item.pkt_tag == swrp_pkg::TAG_SYN) && hdr_ok) begin
                            n_rs_tag               = swrp_pkg::TAG_SYNACK;
                            n_rs_seq               = i_item.pkt_seq;
                            n_rs_ds                = i_item.pkt_datasize;
                            n_timer                = '0;
                            n_phase                = PH_WAIT_ACK;
                            qwr.count              = 2'd1;
                            qwr.act0.send_valid    = 1'b1;
                            qwr.act0.send_tag      = swrp_pkg::TAG_SYNACK;
                            qwr.act0.send_seq      = i_item.pkt_seq;
                            qwr.act0.send_datasize = i_item.pkt_datasize;
                        end
                    end
                    PH_WAIT_ACK: begin
                        n_phase         = PH_DATA;
                        qwr.count       = 2'd1;
                        qwr.act0.status = ((i_item.pkt_tag == swrp_pkg::TAG_ACK) && hdr_ok)
                                          ? swrp_pkg::ST_CONNECTED : swrp_pkg::ST_CONN_FAIL;
                    end
                    PH_DATA: begin
                        qwr.count = 2'd1;
                        if ((i_item.pkt_tag == swrp_pkg::TAG_OVER) && hdr_ok) begin
                            n_files_done        = files_inc;
                            n_file_bytes        = '0;
                            n_exp_seq           = '0;
                            n_last_ack          = '0;
                            // A setting of zero still finishes after the first file.
                            if (files_inc >= r_files_cfg) begin
                                n_phase = PH_WAIT_FIN;
                            end
                            qwr.act0.send_valid = 1'b1;
                            qwr.act0.send_tag   = swrp_pkg::TAG_OVER;
                            qwr.act0.send_seq   = r_last_ack;
                            qwr.act0.status     = swrp_pkg::ST_FILE_DONE;
                        end else if (i_item.pkt_seq != r_exp_seq) begin
                            qwr.act0.status = swrp_pkg::ST_DUPLICATE;
                        end else begin
                            n_file_bytes         = byte_sum[32] ? 32'hffff_ffff
                                                                : byte_sum[31:0];
                            n_last_ack           = r_exp_seq;
                            n_exp_seq            = r_exp_seq + 8'd1;
                            qwr.act0.send_valid  = 1'b1;
                            qwr.act0.send_tag    = swrp_pkg::TAG_ACK;
                            qwr.act0.send_seq    = r_exp_seq;
                            qwr.act0.deliver     = 1'b1;
                            qwr.act0.deliver_len = len;
                            qwr.act0.byte_count  = n_file_bytes;
                        end
                    end
                    PH_WAIT_FIN: begin
                        if ((i_item.pkt_tag == swrp_pkg::TAG_FIN) && hdr_ok) begin
                            n_rs_tag               = swrp_pkg::TAG_FINACK;
                            n_rs_seq               = i_item.pkt_seq;
                            n_rs_ds                = i_item.pkt_datasize;
                            n_timer                = '0;
                            n_phase                = PH_WAIT_LAST;
                            qwr.count              = 2'd2;
                            qwr.act0.send_valid    = 1'b1;
                            qwr.act0.send_tag      = swrp_pkg::TAG_ACK;
                            qwr.act0.send_seq      = i_item.pkt_seq;
                            qwr.act0.send_datasize = i_item.pkt_datasize;
                            qwr.act0.last          = 1'b0;
                            qwr.act1.send_valid    = 1'b1;
                            qwr.act1.send_tag      = swrp_pkg::TAG_FINACK;
                            qwr.act1.send_seq      = i_item.pkt_seq;
                            qwr.act1.send_datasize = i_item.pkt_datasize;
                        end
                    end
                    PH_WAIT_LAST: begin
                        n_phase         = PH_CLOSED;
                        qwr.count       = 2'd1;
                        qwr.act0.status = ((i_item.pkt_tag == swrp_pkg::TAG_ACK) && hdr_ok)
                                          ? swrp_pkg::ST_CLOSED : swrp_pkg::ST_CLOSE_FAIL;
                    end
                    PH_CLOSED: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_qwr = qwr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT_SYN;
            r_exp_seq    <= '0;
            r_timer      <= '0;
            r_rs_tag     <= '0;
            r_rs_seq     <= '0;
            r_rs_ds      <= '0;
            r_files_done <= '0;
            r_file_bytes <= '0;
            r_last_ack   <= '0;
            r_timeout    <= swrp_pkg::TIMEOUT_RESET;
            r_files_cfg  <= swrp_pkg::FILES_RESET;
        end else begin
            r_phase      <= n_phase;
            r_exp_seq    <= n_exp_seq;
            r_timer      <= n_timer;
            r_rs_tag     <= n_rs_tag;
            r_rs_seq     <= n_rs_seq;
            r_rs_ds      <= n_rs_ds;
            r_files_done <= n_files_done;
            r_file_bytes <= n_file_bytes;
            r_last_ack   <= n_last_ack;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    swrp_pkg::REG_TIMEOUT: r_timeout   <= i_cfg_wdata;
                    swrp_pkg::REG_FILES:   r_files_cfg <= i_cfg_wdata[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- rtl/swrp_queue.sv -----
// Action queue between front and back: up to two writes and one read per cycle.
`timescale 1ns / 1ps
module swrp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swrp_pkg::t_qwrite   i_wr,
    input  logic                i_rd,
    output swrp_pkg::t_action   o_rd_data,
    output logic                o_empty,
    output logic                o_full
);

    swrp_pkg::t_action r_mem [swrp_pkg::QDEPTH];

    logic [swrp_pkg::QPTR_W-1:0] r_wp, n_wp;
    logic [swrp_pkg::QPTR_W-1:0] r_rp, n_rp;
    logic [swrp_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    logic [swrp_pkg::QPTR_W-1:0] wp1;
    logic                        do_rd;

    assign wp1       = r_wp + swrp_pkg::QPTR_W'(1);
    assign do_rd     = i_rd && !o_empty;
    assign o_empty   = (r_cnt == '0);
    // Full as soon as a two-result request might not fit.
    assign o_full    = (r_cnt > swrp_pkg::QCNT_W'(swrp_pkg::QDEPTH - 2));
    assign o_rd_data = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp + swrp_pkg::QPTR_W'(i_wr.count);
        n_rp  = do_rd ? (r_rp + swrp_pkg::QPTR_W'(1)) : r_rp;
        n_cnt = r_cnt + swrp_pkg::QCNT_W'(i_wr.count) - swrp_pkg::QCNT_W'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.count != 2'd0) begin
            r_mem[r_wp] <= i_wr.act0;
        end
        if (i_wr.count == 2'd2) begin
            r_mem[wp1] <= i_wr.act1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/swrp_back.sv -----
// Back part: builds the outgoing header checksum and holds the result register.
`timescale 1ns / 1ps
module swrp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swrp_pkg::t_action   i_act,
    input  logic                i_act_empty,
    output logic                o_act_rd,
    input  logic                i_pop,
    output logic                o_empty,
    output swrp_pkg::t_out_item o_item
);

    logic                r_vld;
    swrp_pkg::t_out_item r_item, n_item;
    logic                load;

    assign load     = !r_vld || i_pop;
    assign o_act_rd = load && !i_act_empty;
    assign o_empty  = !r_vld;
    assign o_item   = r_item;

    always_comb begin
        n_item.send_valid    = i_act.send_valid;
        n_item.send_tag      = i_act.send_tag;
        n_item.send_seq      = i_act.send_seq;
        n_item.send_datasize = i_act.send_datasize;
        n_item.send_checksum = i_act.send_valid
                               ? swrp_pkg::ones_sum(i_act.send_datasize, 16'd0,
                                                    {i_act.send_seq, i_act.send_tag})
                               : 16'd0;
        n_item.last          = i_act.last;
        n_item.deliver       = i_act.deliver;
        n_item.deliver_len   = i_act.deliver_len;
        n_item.file_index    = i_act.file_index;
        n_item.byte_count    = i_act.byte_count;
        n_item.status        = i_act.status;
    end

    always_ff @(posedge i_clk) begin
        if (o_act_rd) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= !i_act_empty;
        end
    end

endmodule

// ----- rtl/stop_wait_receiver_protocol_core.sv -----
// Top level of the stop-and-wait receiver: front, action queue and back.
`timescale 1ns / 1ps
// The block takes one request per clock while full is low: a received header
// or a timer tick. The protocol state machine in the front settles each request
// in the cycle it is accepted and writes its results (none, one, or two for a
// FIN) into a four-entry queue; the back adds the header checksum and presents
// the oldest result in an output register that it loads from the queue.
// Results leave at one per pop, so a FIN costs two pops. full rises while the
// queue has fewer than two free entries. Configuration writes take effect at
// once and should be made only while no request is in flight.
module stop_wait_receiver_protocol_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [swrp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                    i_cfg_wdata,
    input  logic                           push,
    output logic                           full,
    input  swrp_pkg::t_in_item             i_in_item,
    output logic                           empty,
    input  logic                           pop,
    output swrp_pkg::t_out_item            o_out_item
);

    swrp_pkg::t_qwrite qwr;
    swrp_pkg::t_action q_data;
    logic              q_empty;
    logic              q_full;
    logic              q_rd;

    assign full = q_full;

    swrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (push && !q_full),
        .i_item      (i_in_item),
        .o_qwr       (qwr)
    );

    swrp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (qwr),
        .i_rd      (q_rd),
        .o_rd_data (q_data),
        .o_empty   (q_empty),
        .o_full    (q_full)
    );

    swrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_act       (q_data),
        .i_act_empty (q_empty),
        .o_act_rd    (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule

// ----- rtl/swrp_checker.sv -----
// Port-level checks of the stop-and-wait receiver, bound to its top level.
`timescale 1ns / 1ps
module swrp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                empty,
    input logic                pop,
    input swrp_pkg::t_out_item o_out_item
);

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result offered after reset");

    // A result that sends nothing carries an all-zero header.
    a_idle_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.send_valid) |->
        (o_out_item.send_tag == 8'd0 && o_out_item.send_seq == 8'd0 &&
         o_out_item.send_datasize == 16'd0 && o_out_item.send_checksum == 16'd0))
        else $error("header fields set without send_valid");

    // A delivery is always acknowledged and never longer than the payload limit.
    a_deliver_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.deliver) |->
        (o_out_item.send_valid && o_out_item.send_tag == swrp_pkg::TAG_ACK &&
         o_out_item.deliver_len <= swrp_pkg::MAX_LEN))
        else $error("delivery without proper acknowledgement");

    // No delivery length is reported without a delivery.
    a_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.deliver) |-> (o_out_item.deliver_len == 16'd0))
        else $error("delivery length without delivery");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed");

endmodule

bind stop_wait_receiver_protocol_core swrp_checker u_swrp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);
